>>> sv/x86d_pkg.sv
`timescale 1ns / 1ps
package x86d_pkg;

  localparam int ADDR_BITS = 16;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [4:0] CLS_MOV_RM    = 5'd0;
  localparam logic [4:0] CLS_MOV_IRM   = 5'd1;
  localparam logic [4:0] CLS_MOV_IREG  = 5'd2;
  localparam logic [4:0] CLS_MOV_MACC  = 5'd3;
  localparam logic [4:0] CLS_MOV_AMEM  = 5'd4;
  localparam logic [4:0] CLS_MOV_TOSEG = 5'd5;
  localparam logic [4:0] CLS_MOV_FRSEG = 5'd6;
  localparam logic [4:0] CLS_ADD_RM    = 5'd7;
  localparam logic [4:0] CLS_ADD_IACC  = 5'd8;
  localparam logic [4:0] CLS_ADD_IRM   = 5'd9;
  localparam logic [4:0] CLS_SUB_RM    = 5'd10;
  localparam logic [4:0] CLS_SUB_IACC  = 5'd11;
  localparam logic [4:0] CLS_SUB_IRM   = 5'd12;
  localparam logic [4:0] CLS_CMP_RM    = 5'd13;
  localparam logic [4:0] CLS_CMP_IACC  = 5'd14;
  localparam logic [4:0] CLS_CMP_IRM   = 5'd15;
  localparam logic [4:0] CLS_JCC       = 5'd16;
  localparam logic [4:0] CLS_GROUP     = 5'd17;
  localparam logic [4:0] CLS_BAD       = 5'd18;

  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_SUB = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd7;

  localparam logic [2:0] MODE_MEM0   = 3'd0;
  localparam logic [2:0] MODE_MEM8   = 3'd1;
  localparam logic [2:0] MODE_MEM16  = 3'd2;
  localparam logic [2:0] MODE_REG    = 3'd3;
  localparam logic [2:0] MODE_DIRECT = 3'd4;
  localparam logic [2:0] RM_DIRECT   = 3'b110;

  typedef struct packed {
    logic        status;
    logic [4:0]  op_class;
    logic [7:0]  opcode_byte;
    logic        wide;
    logic        reg_is_dest;
    logic [2:0]  reg_field;
    logic [2:0]  operand_mode;
    logic [2:0]  rm_field;
    logic [15:0] displacement_or_target;
    logic [15:0] immediate;
    logic [2:0]  length;
    logic [15:0] instr_address;
  } rec_t;

  function automatic logic [15:0] sext8(input logic [7:0] x);
    sext8 = {{8{x[7]}}, x};
  endfunction

  function automatic logic [4:0] first_class(input logic [7:0] b);
    if ((b & 8'b11111100) == 8'b10001000) first_class = CLS_MOV_RM;
    else if ((b & 8'hFE) == 8'b11000110)  first_class = CLS_MOV_IRM;
    else if ((b & 8'hF0) == 8'b10110000)  first_class = CLS_MOV_IREG;
    else if ((b & 8'hFE) == 8'hA0)        first_class = CLS_MOV_MACC;
    else if ((b & 8'hFE) == 8'hA2)        first_class = CLS_MOV_AMEM;
    else if (b == 8'h8E)                  first_class = CLS_MOV_TOSEG;
    else if (b == 8'h8C)                  first_class = CLS_MOV_FRSEG;
    else if ((b & 8'hFC) == 8'h00)        first_class = CLS_ADD_RM;
    else if ((b & 8'hFE) == 8'h04)        first_class = CLS_ADD_IACC;
    else if ((b & 8'hFC) == 8'h80)        first_class = CLS_GROUP;
    else if ((b & 8'hFC) == 8'h28)        first_class = CLS_SUB_RM;
    else if ((b & 8'hFE) == 8'h2C)        first_class = CLS_SUB_IACC;
    else if ((b & 8'hFC) == 8'b00111000)  first_class = CLS_CMP_RM;
    else if ((b & 8'hFE) == 8'h3C)        first_class = CLS_CMP_IACC;
    else if ((b & 8'hF0) == 8'h70 || (b & 8'hFC) == 8'hE0) first_class = CLS_JCC;
    else                                  first_class = CLS_BAD;
  endfunction

  function automatic logic has_modrm(input logic [4:0] c);
    has_modrm = (c == CLS_MOV_RM) || (c == CLS_MOV_IRM) || (c == CLS_MOV_TOSEG) ||
                (c == CLS_MOV_FRSEG) || (c == CLS_ADD_RM) || (c == CLS_ADD_IRM) ||
                (c == CLS_SUB_RM) || (c == CLS_SUB_IRM) || (c == CLS_CMP_RM) ||
                (c == CLS_CMP_IRM);
  endfunction

endpackage

>>> sv/x86d_front.sv
`timescale 1ns / 1ps
module x86d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_in,
  output logic              rec_vld,
  output x86d_pkg::rec_t    rec
);
  import x86d_pkg::*;

  logic [7:0]           store_r [6];
  logic [2:0]           held_r;
  logic [ADDR_BITS-1:0] ofs_r;
  logic                 halted_r;

  logic [7:0]  bv [6];
  logic [2:0]  n;
  logic [4:0]  cls;
  logic [2:0]  db;
  logic [2:0]  len;
  logic        data_wide;
  logic        done;
  logic        bad;
  logic [2:0]  p;

  // view of the bytes including the one arriving now
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      bv[k] = (held_r == 3'(k)) ? byte_in : store_r[k];
    end
  end

  // classify and decode the collected bytes
  always_comb begin
    n         = held_r + 3'd1;
    cls       = first_class(bv[0]);
    db        = 3'd0;
    len       = 3'd2;
    data_wide = 1'b0;
    done      = 1'b0;
    bad       = 1'b0;
    p         = 3'd0;
    rec       = '0;
    rec.opcode_byte   = bv[0];
    rec.instr_address = ofs_r[15:0];

    if (cls == CLS_GROUP) begin
      if (n < 3'd2) cls = CLS_GROUP;
      else if (bv[1][5:3] == GRP_ADD) cls = CLS_ADD_IRM;
      else if (bv[1][5:3] == GRP_SUB) cls = CLS_SUB_IRM;
      else if (bv[1][5:3] == GRP_CMP) cls = CLS_CMP_IRM;
      else cls = CLS_BAD;
    end

    if (cls == CLS_BAD) begin
      bad        = 1'b1;
      done       = 1'b1;
      rec.status = 1'b1;
      rec.length = n;
    end else if (cls != CLS_GROUP && !(has_modrm(cls) && n < 3'd2)) begin
      if (has_modrm(cls)) begin
        case (bv[1][7:6])
          2'd0:    db = (bv[1][2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
          2'd1:    db = 3'd1;
          2'd2:    db = 3'd2;
          default: db = 3'd0;
        endcase
        rec.rm_field     = bv[1][2:0];
        rec.operand_mode = {1'b0, bv[1][7:6]};
        if (bv[1][7:6] == 2'd0 && bv[1][2:0] == RM_DIRECT) rec.operand_mode = MODE_DIRECT;
      end
      case (cls)
        CLS_MOV_RM, CLS_ADD_RM, CLS_SUB_RM, CLS_CMP_RM: begin
          rec.wide = bv[0][0]; rec.reg_is_dest = bv[0][1]; rec.reg_field = bv[1][5:3];
          len = 3'd2 + db;
        end
        CLS_MOV_IRM: begin
          rec.wide = bv[0][0]; data_wide = bv[0][0];
          len = 3'd2 + db + (data_wide ? 3'd2 : 3'd1);
        end
        CLS_MOV_IREG: begin
          rec.wide = bv[0][3]; rec.reg_is_dest = 1'b1; rec.reg_field = bv[0][2:0];
          rec.operand_mode = MODE_REG; data_wide = bv[0][3];
          len = data_wide ? 3'd3 : 3'd2;
        end
        CLS_MOV_MACC, CLS_MOV_AMEM: begin
          rec.wide = bv[0][0]; rec.reg_is_dest = (cls == CLS_MOV_MACC);
          rec.operand_mode = MODE_DIRECT; rec.rm_field = RM_DIRECT;
          len = 3'd3;
        end
        CLS_MOV_TOSEG, CLS_MOV_FRSEG: begin
          rec.wide = 1'b1; rec.reg_is_dest = (cls == CLS_MOV_TOSEG);
          rec.reg_field = {1'b0, bv[1][4:3]};
          len = 3'd2 + db;
        end
        CLS_ADD_IACC, CLS_SUB_IACC, CLS_CMP_IACC: begin
          rec.wide = bv[0][0]; rec.reg_is_dest = 1'b1; rec.operand_mode = MODE_REG;
          data_wide = bv[0][0];
          len = data_wide ? 3'd3 : 3'd2;
        end
        CLS_ADD_IRM, CLS_SUB_IRM, CLS_CMP_IRM: begin
          rec.wide = bv[0][0]; data_wide = bv[0][0] & ~bv[0][1];
          len = 3'd2 + db + (data_wide ? 3'd2 : 3'd1);
        end
        default: len = 3'd2;
      endcase
      rec.op_class = cls;
      rec.length   = len;
      done         = (n >= len);

      // displacement, address or jump target
      if (has_modrm(cls)) begin
        if (db == 3'd1) rec.displacement_or_target = sext8(bv[2]);
        else if (db == 3'd2) rec.displacement_or_target = {bv[3], bv[2]};
      end
      if (cls == CLS_MOV_MACC || cls == CLS_MOV_AMEM)
        rec.displacement_or_target = {bv[2], bv[1]};
      if (cls == CLS_JCC)
        rec.displacement_or_target = ofs_r[15:0] + 16'd2 + sext8(bv[1]);

      // immediate data
      p = 3'd2 + db;
      if (cls == CLS_MOV_IRM || cls == CLS_ADD_IRM || cls == CLS_SUB_IRM ||
          cls == CLS_CMP_IRM) begin
        if (data_wide) rec.immediate = {bv[p + 3'd1], bv[p]};
        else if (cls == CLS_MOV_IRM) rec.immediate = {8'h00, bv[p]};
        else rec.immediate = sext8(bv[p]);
      end else if (cls == CLS_MOV_IREG || cls == CLS_ADD_IACC ||
                   cls == CLS_SUB_IACC || cls == CLS_CMP_IACC) begin
        rec.immediate = data_wide ? {bv[2], bv[1]} : sext8(bv[1]);
      end
    end
  end

  assign rec_vld = byte_vld && !halted_r && done;

  // hold incoming bytes
  always_ff @(posedge clk) begin
    if (byte_vld && !halted_r) store_r[held_r] <= byte_in;
  end

  // advance collector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 3'd0;
      ofs_r    <= '0;
      halted_r <= 1'b0;
    end else if (byte_vld && !halted_r) begin
      if (done) begin
        held_r <= 3'd0;
        if (bad) halted_r <= 1'b1;
        else ofs_r <= ofs_r + ADDR_BITS'(len);
      end else begin
        held_r <= n;
      end
    end
  end

endmodule

>>> sv/x86d_queue.sv
`timescale 1ns / 1ps
module x86d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  x86d_pkg::rec_t wr_rec,
  output logic           q_full,
  output logic           q_empty,
  input  logic           rd_en,
  output x86d_pkg::rec_t rd_rec
);
  import x86d_pkg::*;

  rec_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r;
  logic [Q_PTR_W-1:0] rp_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign q_full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_rec  = mem_r[rp_r];

  // store beats
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_rec;
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W+1)'(Q_DEPTH)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[Q_PTR_W-1:0]) else $error("queue pointers disagree with count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count step");

endmodule

>>> sv/x86_16bit_instruction_decoder.sv
`timescale 1ns / 1ps
// 16-bit x86 instruction decoder, subset: mov forms, add/sub/cmp, short jumps.
// Input channel: one instruction byte per beat on in_byte, taken when push is
//   high and full is low.
// Result channel: one decoded record per instruction, shown while empty is
//   low and taken when pop is high. out_status 1 marks an unhandled opcode,
//   after which the block drops all bytes until reset.
// A record enters the result queue on the edge that takes the last byte of
//   its instruction and is visible in the following cycle.
// Throughput: one byte per cycle while full is low, set by the combinational byte classifier.
// A four-entry result queue parts the sides; when the receiver stalls the
//   queue fills and full rises, holding off further bytes.
// Reset (rst_n low, synchronous) clears the byte count, the stream offset,
//   the halt flag and the queue.
module x86_16bit_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_status,
  output logic [4:0]  out_op_class,
  output logic [7:0]  out_opcode_byte,
  output logic        out_wide,
  output logic        out_reg_is_dest,
  output logic [2:0]  out_reg_field,
  output logic [2:0]  out_operand_mode,
  output logic [2:0]  out_rm_field,
  output logic [15:0] out_displacement_or_target,
  output logic [15:0] out_immediate,
  output logic [2:0]  out_length,
  output logic [15:0] out_instr_address
);
  import x86d_pkg::*;

  logic rec_vld;
  rec_t rec;
  rec_t q_rec;
  logic q_full;

  assign full = q_full;

  x86d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (push && !q_full),
    .byte_in  (in_byte),
    .rec_vld  (rec_vld),
    .rec      (rec)
  );

  x86d_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rec_vld),
    .wr_rec  (rec),
    .q_full  (q_full),
    .q_empty (empty),
    .rd_en   (pop),
    .rd_rec  (q_rec)
  );

  // unpack the head record
  assign out_status                 = q_rec.status;
  assign out_op_class               = q_rec.op_class;
  assign out_opcode_byte            = q_rec.opcode_byte;
  assign out_wide                   = q_rec.wide;
  assign out_reg_is_dest            = q_rec.reg_is_dest;
  assign out_reg_field              = q_rec.reg_field;
  assign out_operand_mode           = q_rec.operand_mode;
  assign out_rm_field               = q_rec.rm_field;
  assign out_displacement_or_target = q_rec.displacement_or_target;
  assign out_immediate              = q_rec.immediate;
  assign out_length                 = q_rec.length;
  assign out_instr_address          = q_rec.instr_address;

endmodule
